@@ rtl/core/mopalu_pkg.sv @@
// shared types and constants for the micro-op alu with flags
package mopalu_pkg;

    localparam int unsigned DATA_W        = 16;
    localparam int unsigned IDX_W         = 5;
    localparam int unsigned ACT_W         = 5;
    localparam int unsigned REG_COUNT_DEF = 20;

    localparam logic [DATA_W-1:0] FLAG_KEEP_MASK = 16'hFFF0;
    localparam logic [DATA_W-1:0] SIGN_BIT       = 16'h8000;

    // operation codes
    typedef enum logic [ACT_W-1:0] {
        ACT_MOVI     = 5'd0,
        ACT_MOV      = 5'd1,
        ACT_ADDI     = 5'd2,
        ACT_ADD      = 5'd3,
        ACT_ADC      = 5'd4,
        ACT_SUB      = 5'd5,
        ACT_SBC      = 5'd6,
        ACT_NEG      = 5'd7,
        ACT_CMP      = 5'd8,
        ACT_NOT      = 5'd9,
        ACT_AND      = 5'd10,
        ACT_OR       = 5'd11,
        ACT_XOR      = 5'd12,
        ACT_SL       = 5'd13,
        ACT_SR       = 5'd14,
        ACT_SRA      = 5'd15,
        ACT_RL       = 5'd16,
        ACT_RR       = 5'd17,
        ACT_RLC      = 5'd18,
        ACT_RRC      = 5'd19,
        ACT_CLRFLAGS = 5'd20,
        ACT_SETFLAGS = 5'd21,
        ACT_XORFLAGS = 5'd22,
        ACT_MASKLOAD = 5'd23
    } t_action;

    // alu outcome handed back to the pipeline
    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [DATA_W-1:0] status;
        logic              wr_en;
    } t_alu_res;

endpackage

@@ rtl/core/micro_op_alu_with_flags_unit.sv @@
// top level: micro-op alu with register file, status word and stream ports
//
// Takes one micro-op beat per cycle while the output side is not stalled and
// returns one result beat per micro-op, through the stage 1 registers and the
// output register. The accepting edge reads both operands from the register
// file ram (registered read); the following cycle runs the alu, and the edge
// at which stage 1 fires writes back the destination and the status word and
// loads the output register. A write at that edge is forwarded to a micro-op
// accepted at the same edge, so dependent micro-ops issue back to back.
// Register indexes at or above REGISTER_COUNT read as zero and are not written.
// After reset every register reads zero through per-entry valid bits; no
// clearing pass is needed. Unused opcodes change nothing and return zero.
module micro_op_alu_with_flags_unit
    import mopalu_pkg::*;
#(
    parameter int unsigned REGISTER_COUNT = REG_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action[4:0], dest_index[9:5], source_index[14:10], immediate[30:15], zero[31]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_value[15:0], status_out[31:16]
    output logic [31:0] m_axis_tdata
);

    localparam int unsigned AW = $clog2(REGISTER_COUNT);

    logic              accept;
    logic              fire;
    t_action           in_act;
    logic [IDX_W-1:0]  in_di;
    logic [IDX_W-1:0]  in_si;
    logic [DATA_W-1:0] in_imm;
    logic              di_ok;
    logic              si_ok;
    logic [AW-1:0]     di_addr;
    logic [AW-1:0]     si_addr;
    logic              a_hit;
    logic              b_hit;
    logic [DATA_W-1:0] ram_a;
    logic [DATA_W-1:0] ram_b;
    logic [DATA_W-1:0] op_a;
    logic [DATA_W-1:0] op_b;
    logic              do_wr;
    t_alu_res          alu_res;

    // stage 1 registers
    logic                      r_s1_valid;
    t_action                   r_act;
    logic [DATA_W-1:0]         r_imm;
    logic [AW-1:0]             r_dest_addr;
    logic                      r_dest_ok;
    logic                      r_a_live;
    logic                      r_b_live;
    logic                      r_a_byp;
    logic                      r_b_byp;
    logic [DATA_W-1:0]         r_byp_data;
    logic [REGISTER_COUNT-1:0] r_vld;
    logic [DATA_W-1:0]         r_status;

    // output register
    logic              r_out_valid;
    logic [2*DATA_W-1:0] r_out_data;

    // input beat fields
    assign in_act = t_action'(s_axis_tdata[ACT_W-1:0]);
    assign in_di  = s_axis_tdata[ACT_W+IDX_W-1:ACT_W];
    assign in_si  = s_axis_tdata[ACT_W+2*IDX_W-1:ACT_W+IDX_W];
    assign in_imm = s_axis_tdata[ACT_W+2*IDX_W+DATA_W-1:ACT_W+2*IDX_W];

    assign di_ok   = ({1'b0, in_di} < (IDX_W+1)'(REGISTER_COUNT));
    assign si_ok   = ({1'b0, in_si} < (IDX_W+1)'(REGISTER_COUNT));
    assign di_addr = in_di[AW-1:0];
    assign si_addr = in_si[AW-1:0];

    // handshake
    assign fire          = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // write-back and same-cycle forward
    assign do_wr = fire && alu_res.wr_en && r_dest_ok;
    assign a_hit = do_wr && di_ok && (r_dest_addr == di_addr);
    assign b_hit = do_wr && si_ok && (r_dest_addr == si_addr);

    mopalu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REGISTER_COUNT)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_we      (do_wr),
        .i_waddr   (r_dest_addr),
        .i_wdata   (alu_res.result),
        .i_re      (accept),
        .i_raddr_a (di_addr),
        .i_raddr_b (si_addr),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // stage 1 payload and operand selects
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act       <= in_act;
            r_imm       <= in_imm;
            r_dest_addr <= di_addr;
            r_dest_ok   <= di_ok;
            r_a_live    <= di_ok && r_vld[di_addr];
            r_b_live    <= si_ok && r_vld[si_addr];
            r_a_byp     <= a_hit;
            r_b_byp     <= b_hit;
            r_byp_data  <= alu_res.result;
        end
    end

    // valid bits stand in for the register reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (do_wr) begin
            r_vld[r_dest_addr] <= 1'b1;
        end
    end

    // operand pick: forwarded, stored or zero
    always_comb begin
        if (r_a_byp) begin
            op_a = r_byp_data;
        end else if (r_a_live) begin
            op_a = ram_a;
        end else begin
            op_a = '0;
        end
        if (r_b_byp) begin
            op_b = r_byp_data;
        end else if (r_b_live) begin
            op_b = ram_b;
        end else begin
            op_b = '0;
        end
    end

    mopalu_alu u_alu (
        .i_action (r_act),
        .i_a      (op_a),
        .i_b      (op_b),
        .i_imm    (r_imm),
        .i_status (r_status),
        .o_res    (alu_res)
    );

    // working status word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
        end else if (fire) begin
            r_status <= alu_res.status;
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {alu_res.status, alu_res.result};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ rtl/core/mopalu_ram.sv @@
// generic ram: one write port, two registered read ports
module mopalu_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 20
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered reads, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/core/mopalu_alu.sv @@
// combinational 16-bit alu with zero, sign, carry and overflow flags
module mopalu_alu
    import mopalu_pkg::*;
(
    input  t_action           i_action,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    input  logic [DATA_W-1:0] i_imm,
    input  logic [DATA_W-1:0] i_status,
    output t_alu_res          o_res
);

    // zero and sign bits of a result
    function automatic logic [1:0] zs_bits(input logic [DATA_W-1:0] r);
        zs_bits = {r[DATA_W-1], (r == '0)};
    endfunction

    // default arithmetic flags: carry is r < a, overflow from sign bits
    function automatic logic [3:0] arith_flags(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b,
                                                input logic [DATA_W-1:0] r);
        logic c;
        logic o;
        c = (r < a);
        o = (a[DATA_W-1] == b[DATA_W-1]) && (a[DATA_W-1] != r[DATA_W-1]);
        arith_flags = {o, c, zs_bits(r)};
    endfunction

    logic              cin;
    logic [DATA_W-1:0] cin_w;
    logic [DATA_W-1:0] nb;
    logic [DATA_W-1:0] sum_ab;
    logic [DATA_W-1:0] sum_ai;
    logic [DATA_W-1:0] sum_adc;
    logic [DATA_W-1:0] dif_ab;
    logic [DATA_W-1:0] dif_sbc;
    logic [DATA_W-1:0] r;
    logic [3:0]        low;
    logic              set_low;
    logic [DATA_W-1:0] status_full;
    logic              full_st;
    logic              wr_en;

    // shared adders
    assign cin     = i_status[2];
    assign cin_w   = {{(DATA_W-1){1'b0}}, cin};
    assign nb      = ~i_b + {{(DATA_W-1){1'b0}}, 1'b1};
    assign sum_ab  = i_a + i_b;
    assign sum_ai  = i_a + i_imm;
    assign sum_adc = sum_ab + cin_w;
    assign dif_ab  = i_a + nb;
    assign dif_sbc = dif_ab - cin_w;

    // operation decode
    always_comb begin
        r           = '0;
        low         = '0;
        set_low     = 1'b0;
        status_full = i_status;
        full_st     = 1'b0;
        wr_en       = 1'b0;
        unique case (i_action) inside
            ACT_MOVI: begin
                r     = i_imm;
                wr_en = 1'b1;
            end
            ACT_MOV: begin
                r     = i_b;
                wr_en = 1'b1;
            end
            ACT_ADDI: begin
                r       = sum_ai;
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = arith_flags(i_a, i_imm, sum_ai);
            end
            ACT_ADD: begin
                r       = sum_ab;
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = arith_flags(i_a, i_b, sum_ab);
            end
            ACT_ADC: begin
                r       = sum_adc;
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = arith_flags(i_a, i_b, sum_adc);
                // carry quirk: result equal to a with a nonzero addend
                if (sum_adc == i_a && i_b != '0) begin
                    low[2] = 1'b1;
                end
            end
            ACT_SUB, ACT_CMP: begin
                r       = dif_ab;
                wr_en   = (i_action == ACT_SUB);
                set_low = 1'b1;
                low     = arith_flags(i_a, nb, dif_ab);
            end
            ACT_SBC: begin
                r       = dif_sbc;
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = arith_flags(i_a, nb, dif_sbc);
                if (dif_sbc == i_a && nb != '0) begin
                    low[2] = 1'b1;
                end
            end
            ACT_NEG: begin
                r       = nb;
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = {(nb == SIGN_BIT), 1'b0, zs_bits(nb)};
            end
            ACT_NOT: begin
                r       = ~i_b;
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = {2'b00, zs_bits(~i_b)};
            end
            ACT_AND: begin
                r       = i_a & i_b;
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = {2'b00, zs_bits(i_a & i_b)};
            end
            ACT_OR: begin
                r       = i_a | i_b;
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = {2'b00, zs_bits(i_a | i_b)};
            end
            ACT_XOR: begin
                r       = i_a ^ i_b;
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = {2'b00, zs_bits(i_a ^ i_b)};
            end
            ACT_SL: begin
                r       = {i_a[DATA_W-2:0], 1'b0};
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = {1'b0, i_a[DATA_W-1], zs_bits({i_a[DATA_W-2:0], 1'b0})};
            end
            ACT_SR: begin
                r       = {1'b0, i_a[DATA_W-1:1]};
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = {1'b0, i_a[0], zs_bits({1'b0, i_a[DATA_W-1:1]})};
            end
            ACT_SRA: begin
                r       = {i_a[DATA_W-1], i_a[DATA_W-1:1]};
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = {1'b0, i_a[0], zs_bits({i_a[DATA_W-1], i_a[DATA_W-1:1]})};
            end
            ACT_RL: begin
                r       = {i_a[DATA_W-2:0], i_a[DATA_W-1]};
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = {1'b0, i_a[DATA_W-1], zs_bits({i_a[DATA_W-2:0], i_a[DATA_W-1]})};
            end
            ACT_RR: begin
                r       = {i_a[0], i_a[DATA_W-1:1]};
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = {1'b0, i_a[0], zs_bits({i_a[0], i_a[DATA_W-1:1]})};
            end
            ACT_RLC: begin
                r       = {i_a[DATA_W-2:0], cin};
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = {1'b0, i_a[DATA_W-1], zs_bits({i_a[DATA_W-2:0], cin})};
            end
            ACT_RRC: begin
                r       = {cin, i_a[DATA_W-1:1]};
                wr_en   = 1'b1;
                set_low = 1'b1;
                low     = {1'b0, i_a[0], zs_bits({cin, i_a[DATA_W-1:1]})};
            end
            ACT_CLRFLAGS: begin
                full_st     = 1'b1;
                status_full = i_status & ~i_imm;
            end
            ACT_SETFLAGS: begin
                full_st     = 1'b1;
                status_full = i_status | i_imm;
            end
            ACT_XORFLAGS: begin
                full_st     = 1'b1;
                status_full = i_status ^ i_imm;
            end
            ACT_MASKLOAD: begin
                full_st     = 1'b1;
                status_full = (i_status & ~i_imm) | (i_b & i_imm);
            end
            default: begin
                r = '0;
            end
        endcase
    end

    // status merge: low nibble rewrite keeps the upper bits; flag ops set the whole word
    always_comb begin
        o_res.result = r;
        o_res.wr_en  = wr_en;
        if (set_low) begin
            o_res.status = (i_status & FLAG_KEEP_MASK) | {{(DATA_W-4){1'b0}}, low};
        end else if (full_st) begin
            o_res.status = status_full;
        end else begin
            o_res.status = i_status;
        end
    end

endmodule
